FILE: sv/cle_pkg.sv
// Shared types and constants for the console line editor.
// Used by the controller, the datapath and the top level; depends on nothing.
package cle_pkg;

    localparam int LINE_DEPTH_DEFAULT = 32;

    localparam int CHAR_W  = 8;
    localparam int LIMIT_W = 6;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHAR_W-1:0] CH_EOT = 8'h04;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SP  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7f;

    localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CR_TO_NL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LIMIT  = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_EMPTY = 2'd2,
        KIND_EOF   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        SEL_CHAR,
        SEL_BS,
        SEL_SP,
        SEL_LINE,
        SEL_EMPTY,
        SEL_EOF
    } sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_ERASE_BS1,
        ST_ERASE_SP,
        ST_ERASE_BS2,
        ST_ECHO,
        ST_DISPATCH,
        ST_REL_PRIME,
        ST_REL_EMIT,
        ST_MARK
    } state_t;

    typedef struct packed {
        logic accept;
        logic dec_fill;
        logic store;
        logic clear_fill;
        logic idx_clear;
        logic idx_inc;
        logic out_load;
        sel_t out_sel;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        logic is_erase;
        logic is_eot;
        logic echo_en;
        logic fill_zero;
        logic release_line;
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

FILE: sv/cle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package dependency.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/cle_ctrl.sv
// Controller state machine for the console line editor.
// Depends on cle_pkg for the state, command and status types.
module cle_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  cle_pkg::status_t status,
    output cle_pkg::cmd_t    cmd
);

    cle_pkg::state_t state_reg;
    cle_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cle_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cle_pkg::ST_CLASSIFY;
                end
            end
            cle_pkg::ST_CLASSIFY:
            begin
                if (status.is_erase)
                begin
                    state_next = status.echo_en ? cle_pkg::ST_ERASE_BS1 : cle_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = status.echo_en ? cle_pkg::ST_ECHO : cle_pkg::ST_DISPATCH;
                end
            end
            cle_pkg::ST_ERASE_BS1:
            begin
                if (status.out_free)
                begin
                    state_next = cle_pkg::ST_ERASE_SP;
                end
            end
            cle_pkg::ST_ERASE_SP:
            begin
                if (status.out_free)
                begin
                    state_next = cle_pkg::ST_ERASE_BS2;
                end
            end
            cle_pkg::ST_ERASE_BS2:
            begin
                if (status.out_free)
                begin
                    state_next = cle_pkg::ST_IDLE;
                end
            end
            cle_pkg::ST_ECHO:
            begin
                if (status.out_free)
                begin
                    state_next = cle_pkg::ST_DISPATCH;
                end
            end
            cle_pkg::ST_DISPATCH:
            begin
                if (status.is_eot)
                begin
                    state_next = status.fill_zero ? cle_pkg::ST_MARK : cle_pkg::ST_REL_PRIME;
                end
                else
                begin
                    state_next = status.release_line ? cle_pkg::ST_REL_PRIME : cle_pkg::ST_IDLE;
                end
            end
            cle_pkg::ST_REL_PRIME:
            begin
                state_next = cle_pkg::ST_REL_EMIT;
            end
            cle_pkg::ST_REL_EMIT:
            begin
                if (status.out_free && status.idx_last)
                begin
                    state_next = status.is_eot ? cle_pkg::ST_MARK : cle_pkg::ST_IDLE;
                end
            end
            cle_pkg::ST_MARK:
            begin
                if (status.out_free)
                begin
                    state_next = cle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = cle_pkg::SEL_CHAR;
        in_stall    = 1'b1;
        unique case (state_reg)
            cle_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            cle_pkg::ST_CLASSIFY:
            begin
                cmd.dec_fill = status.is_erase;
                cmd.store    = !status.is_erase && !status.is_eot;
            end
            cle_pkg::ST_ERASE_BS1:
            begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = cle_pkg::SEL_BS;
            end
            cle_pkg::ST_ERASE_SP:
            begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = cle_pkg::SEL_SP;
            end
            cle_pkg::ST_ERASE_BS2:
            begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = cle_pkg::SEL_BS;
                cmd.out_last = 1'b1;
            end
            cle_pkg::ST_ECHO:
            begin
                cmd.out_load = status.out_free;
                cmd.out_sel  = cle_pkg::SEL_CHAR;
                cmd.out_last = !status.is_eot && !status.release_line;
            end
            cle_pkg::ST_DISPATCH:
            begin
                cmd.idx_clear = 1'b1;
            end
            cle_pkg::ST_REL_PRIME:
            begin
                cmd.idx_clear = 1'b1;
            end
            cle_pkg::ST_REL_EMIT:
            begin
                cmd.out_load   = status.out_free;
                cmd.out_sel    = cle_pkg::SEL_LINE;
                cmd.out_last   = status.idx_last && !status.is_eot;
                cmd.idx_inc    = status.out_free;
                cmd.clear_fill = status.out_free && status.idx_last && !status.is_eot;
            end
            cle_pkg::ST_MARK:
            begin
                cmd.out_load   = status.out_free;
                cmd.out_sel    = status.fill_zero ? cle_pkg::SEL_EMPTY : cle_pkg::SEL_EOF;
                cmd.out_last   = 1'b1;
                cmd.clear_fill = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register is occupied");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == cle_pkg::ST_CLASSIFY))
        else $error("accepted character not classified next cycle");

    a_erase_echo_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cle_pkg::ST_ERASE_BS1 && status.out_free)
            |=> (state_reg == cle_pkg::ST_ERASE_SP))
        else $error("erase echo sequence broken");

endmodule

FILE: sv/cle_dp.sv
// Datapath for the console line editor: configuration, line store, fill
// count, release index and output register. Depends on cle_pkg and cle_ram.
module cle_dp #(
    parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cle_pkg::CFG_W-1:0]     cfg_data,
    input  logic [cle_pkg::CHAR_W-1:0]    rx_char,
    input  logic                          out_stall,
    input  cle_pkg::cmd_t                 cmd,
    output cle_pkg::status_t              status,
    output logic                          out_valid,
    output logic [1:0]                    kind,
    output logic [cle_pkg::CHAR_W-1:0]    data,
    output logic                          last
);

    localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LINE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > cle_pkg::LIMIT_W) ? CNT_W : cle_pkg::LIMIT_W;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINE_DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(LINE_DEPTH);

    logic                         echo_reg;
    logic                         crnl_reg;
    logic [cle_pkg::LIMIT_W-1:0]  limit_reg;
    logic [cle_pkg::CHAR_W-1:0]   char_reg;
    logic [cle_pkg::CHAR_W-1:0]   char_next;
    logic [CNT_W-1:0]             fill_reg;
    logic [CNT_W-1:0]             fill_next;
    logic [CNT_W-1:0]             idx_reg;
    logic [CNT_W-1:0]             idx_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    cle_pkg::kind_t               out_kind_reg;
    cle_pkg::kind_t               out_kind_next;
    logic [cle_pkg::CHAR_W-1:0]   out_data_reg;
    logic [cle_pkg::CHAR_W-1:0]   out_data_next;
    logic                         out_last_reg;

    logic                         ram_we;
    logic [cle_pkg::CHAR_W-1:0]   ram_rdata;
    logic                         has_room;
    logic [CMP_W-1:0]             limit_eff;
    logic [CNT_W:0]               idx_plus;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg  <= 1'b1;
            crnl_reg  <= 1'b1;
            limit_reg <= cle_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cle_pkg::REG_ECHO_ENABLE: echo_reg  <= cfg_data[0];
                cle_pkg::REG_CR_TO_NL:    crnl_reg  <= cfg_data[0];
                cle_pkg::REG_READ_LIMIT:  limit_reg <= cfg_data[cle_pkg::LIMIT_W-1:0];
                default:                  echo_reg  <= echo_reg;
            endcase
        end
    end

    always_comb
    begin
        char_next = char_reg;
        if (cmd.accept)
        begin
            char_next = (crnl_reg && rx_char == cle_pkg::CH_CR) ? cle_pkg::CH_LF : rx_char;
        end
    end

    assign has_room = (fill_reg < DEPTH_CNT);
    assign ram_we   = cmd.store && has_room;

    always_comb
    begin
        fill_next = fill_reg;
        priority if (cmd.clear_fill)
        begin
            fill_next = '0;
        end
        else if (cmd.dec_fill && fill_reg != '0)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
        else if (ram_we)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        priority if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_comb
    begin
        limit_eff = CMP_W'(limit_reg);
        if (limit_eff == '0)
        begin
            limit_eff = CMP_W'(1);
        end
        else if (limit_eff > DEPTH_CMP)
        begin
            limit_eff = DEPTH_CMP;
        end
    end

    assign idx_plus = {1'b0, idx_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        status.is_erase     = (char_reg == cle_pkg::CH_BS) || (char_reg == cle_pkg::CH_DEL);
        status.is_eot       = (char_reg == cle_pkg::CH_EOT);
        status.echo_en      = echo_reg;
        status.fill_zero    = (fill_reg == '0);
        status.release_line = (char_reg == cle_pkg::CH_LF) || (CMP_W'(fill_reg) >= limit_eff);
        status.idx_last     = (idx_plus == {1'b0, fill_reg});
        status.out_free     = !out_valid_reg || !out_stall;
    end

    cle_ram #(
        .WIDTH (cle_pkg::CHAR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (char_reg),
        .raddr (idx_next[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        unique case (cmd.out_sel)
            cle_pkg::SEL_CHAR:
            begin
                out_kind_next = cle_pkg::KIND_ECHO;
                out_data_next = char_reg;
            end
            cle_pkg::SEL_BS:
            begin
                out_kind_next = cle_pkg::KIND_ECHO;
                out_data_next = cle_pkg::CH_BS;
            end
            cle_pkg::SEL_SP:
            begin
                out_kind_next = cle_pkg::KIND_ECHO;
                out_data_next = cle_pkg::CH_SP;
            end
            cle_pkg::SEL_LINE:
            begin
                out_kind_next = cle_pkg::KIND_LINE;
                out_data_next = ram_rdata;
            end
            cle_pkg::SEL_EMPTY:
            begin
                out_kind_next = cle_pkg::KIND_EMPTY;
                out_data_next = '0;
            end
            cle_pkg::SEL_EOF:
            begin
                out_kind_next = cle_pkg::KIND_EOF;
                out_data_next = '0;
            end
            default:
            begin
                out_kind_next = cle_pkg::KIND_EOF;
                out_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        if (cmd.out_load)
        begin
            out_kind_reg <= out_kind_next;
            out_data_reg <= out_data_next;
            out_last_reg <= cmd.out_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign data      = out_data_reg;
    assign last      = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_CNT)
        else $error("fill count beyond line depth");

    a_line_idx_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_sel == cle_pkg::SEL_LINE) |-> (idx_reg < fill_reg))
        else $error("line byte read past stored fill");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

FILE: sv/console_line_editor_top.sv
// Console line editor top level: one character per transfer in, 0 to
// LINE_DEPTH+1 results out. An item with no result passes the classify state only
// (erase, echo off) or the classify and dispatch states. A line release sends one
// line byte per cycle from the line RAM read port while the output is unstalled.
// One item is worked at a time. Reset clears fill count and output valid, restores
// echo on, CR-to-LF on, read limit 32; line store contents stay undefined.
module console_line_editor_top #(
    parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cle_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cle_pkg::CHAR_W-1:0]    rx_char,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic [cle_pkg::CHAR_W-1:0]    data,
    output logic                          last
);

    cle_pkg::cmd_t    cmd;
    cle_pkg::status_t status;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cle_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_char   (rx_char),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .kind      (kind),
        .data      (data),
        .last      (last)
    );

endmodule
